@@ rtl/byte_ring_buffer_with_offsets_assert.svh @@
// Assertion macros used by the byte ring buffer RTL.
`ifndef BYTE_RING_BUFFER_WITH_OFFSETS_ASSERT_SVH
`define BYTE_RING_BUFFER_WITH_OFFSETS_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BRBO_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BRBO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/brbo_pkg.sv @@
// Package with the word types and action codes of the byte ring buffer.
`default_nettype none

package brbo_pkg;

   localparam int unsigned DATA_W   = 8;
   localparam int unsigned OFFSET_W = 12;
   localparam int unsigned LEN_W    = 13;

   typedef enum logic [1:0] {
      ACT_FILL   = 2'd0,
      ACT_COMMIT = 2'd1,
      ACT_PEEK   = 2'd2,
      ACT_SKIP   = 2'd3
   } action_type;

   typedef struct packed {
      action_type          action;
      logic [DATA_W-1:0]   data_in;
      logic [OFFSET_W-1:0] offset;
      logic [LEN_W-1:0]    length;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [DATA_W-1:0]   data_out;
      logic [LEN_W-1:0]    moved;
      logic [LEN_W-1:0]    fill_level;
      logic [LEN_W-1:0]    free_space;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/byte_ring_buffer_with_offsets.sv @@
// Top level of the circular byte buffer with offset fill and peek access.
`default_nettype none

// A circular store of DEPTH bytes with a read pointer, a write pointer and an
// occupancy count. Every request word carries one action: fill writes a byte at
// the write pointer plus an offset without committing it, commit advances the
// write pointer by a length, peek reads the byte at the read pointer plus an
// offset, and skip advances the read pointer by at most the fill level. Each
// request gives exactly one response word, in order. The block takes one
// request word per clock cycle while the request stall is low; that figure
// is set by the byte memory, which has one write port and one registered
// read port and is touched once per word. The decision and the memory
// access happen at the accepting edge, and the response then passes
// through the decided-word register and a two-entry output queue. The
// request stall is driven from registers only; it rises when a decided
// word is waiting and the output queue is full. Bytes that were committed
// without ever being filled read back as unknown values. Pointers, counts
// and the byte store size follow DEPTH; the length, fill level and free
// space fields are 13 bits wide and carry the low bits of the internal counts.
module byte_ring_buffer_with_offsets #(
   parameter int unsigned DEPTH = 4096
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire brbo_pkg::req_type req_word,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output brbo_pkg::rsp_type   rsp_word
);

   `include "byte_ring_buffer_with_offsets_assert.svh"

   // Pointer width, count width (holds DEPTH itself) and a working width
   // wide enough for every compare against the 12- and 13-bit request fields.
   localparam int unsigned PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned EXT_W =
      ((CNT_W > brbo_pkg::LEN_W) ? CNT_W : brbo_pkg::LEN_W) + 1;
   localparam logic [EXT_W-1:0] DEPTH_X = EXT_W'(DEPTH);

   typedef struct packed {
      logic              peek_ok;
      brbo_pkg::rsp_type rsp;
   } stage_type;

   // Pointer and count state.
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] occ_ff, occ_in;

   // Byte store and its registered read data.
   logic [brbo_pkg::DATA_W-1:0] store_ff [DEPTH];
   logic [brbo_pkg::DATA_W-1:0] rd_data_ff;

   // Decided word waiting for its memory read data.
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;

   // Two-entry output queue that decouples the response side.
   brbo_pkg::rsp_type q_ff [2];
   logic              q_head_ff, q_head_in;
   logic              q_tail_ff, q_tail_in;
   logic [1:0]        q_cnt_ff, q_cnt_in;

   logic              accept;
   logic              push;
   logic              pop;
   logic              wr_en;
   logic [PTR_W-1:0]  mem_addr;
   brbo_pkg::rsp_type push_word;

   logic [EXT_W-1:0] occ_x;
   logic [EXT_W-1:0] free_x;
   logic [EXT_W-1:0] offset_x;
   logic [EXT_W-1:0] length_x;
   logic [EXT_W-1:0] wr_sum;
   logic [EXT_W-1:0] rd_sum;
   logic [EXT_W-1:0] step_x;
   logic [EXT_W-1:0] occ_next_x;

   // The request side only waits on registered state: a decided word that
   // cannot move because the output queue is full.
   assign req_stall = s1_valid_ff && (q_cnt_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign push      = s1_valid_ff && (q_cnt_ff != 2'd2);
   assign pop       = (q_cnt_ff != 2'd0) && !rsp_stall;

   assign rsp_valid = (q_cnt_ff != 2'd0);
   assign rsp_word  = q_ff[q_head_ff];

   assign occ_x    = EXT_W'(occ_ff);
   assign free_x   = DEPTH_X - occ_x;
   assign offset_x = EXT_W'(req_word.offset);
   assign length_x = EXT_W'(req_word.length);

   // Decision for the incoming word. Fills and commits measure from the write
   // pointer, peeks and skips from the read pointer. Every accepted distance
   // stays at or below DEPTH, so one conditional subtract wraps the sum.
   always_comb begin
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      occ_next_x = occ_x;
      step_x     = '0;
      wr_en      = 1'b0;
      wr_sum     = '0;
      rd_sum     = '0;
      mem_addr   = rd_ptr_ff;
      s1_in      = '0;

      case (req_word.action)
         brbo_pkg::ACT_FILL: begin
            wr_sum = EXT_W'(wr_ptr_ff) + offset_x;
            if (wr_sum >= DEPTH_X) begin
               wr_sum = wr_sum - DEPTH_X;
            end
            mem_addr = wr_sum[PTR_W-1:0];
            if (offset_x < free_x) begin
               wr_en        = 1'b1;
               s1_in.rsp.ok = 1'b1;
            end
         end
         brbo_pkg::ACT_COMMIT: begin
            if (length_x <= free_x) begin
               wr_sum = EXT_W'(wr_ptr_ff) + length_x;
               if (wr_sum >= DEPTH_X) begin
                  wr_sum = wr_sum - DEPTH_X;
               end
               wr_ptr_in    = wr_sum[PTR_W-1:0];
               step_x       = length_x;
               occ_next_x   = occ_x + length_x;
               s1_in.rsp.ok = 1'b1;
            end
         end
         brbo_pkg::ACT_PEEK: begin
            rd_sum = EXT_W'(rd_ptr_ff) + offset_x;
            if (rd_sum >= DEPTH_X) begin
               rd_sum = rd_sum - DEPTH_X;
            end
            mem_addr = rd_sum[PTR_W-1:0];
            if (offset_x < occ_x) begin
               s1_in.peek_ok = 1'b1;
               s1_in.rsp.ok  = 1'b1;
            end
         end
         brbo_pkg::ACT_SKIP: begin
            // A skip is clamped to the fill level and is never refused.
            step_x = (length_x < occ_x) ? length_x : occ_x;
            rd_sum = EXT_W'(rd_ptr_ff) + step_x;
            if (rd_sum >= DEPTH_X) begin
               rd_sum = rd_sum - DEPTH_X;
            end
            rd_ptr_in    = rd_sum[PTR_W-1:0];
            occ_next_x   = occ_x - step_x;
            s1_in.rsp.ok = 1'b1;
         end
         default: begin
            s1_in.rsp.ok = 1'b0;
         end
      endcase

      occ_in               = occ_next_x[CNT_W-1:0];
      s1_in.rsp.data_out   = '0;
      s1_in.rsp.moved      = step_x[brbo_pkg::LEN_W-1:0];
      s1_in.rsp.fill_level = occ_next_x[brbo_pkg::LEN_W-1:0];
      s1_in.rsp.free_space = 13'(DEPTH_X - occ_next_x);
   end

   // The peek data joins its word on the way into the output queue.
   always_comb begin
      push_word = s1_ff.rsp;
      if (s1_ff.peek_ok) begin
         push_word.data_out = rd_data_ff;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
      q_tail_in = push ? ~q_tail_ff : q_tail_ff;
      q_head_in = pop ? ~q_head_ff : q_head_ff;
      q_cnt_in  = q_cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         occ_ff      <= '0;
         s1_valid_ff <= 1'b0;
         q_head_ff   <= 1'b0;
         q_tail_ff   <= 1'b0;
         q_cnt_ff    <= 2'd0;
      end else begin
         if (accept) begin
            rd_ptr_ff <= rd_ptr_in;
            wr_ptr_ff <= wr_ptr_in;
            occ_ff    <= occ_in;
         end
         s1_valid_ff <= s1_valid_in;
         q_head_ff   <= q_head_in;
         q_tail_ff   <= q_tail_in;
         q_cnt_ff    <= q_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (push) begin
         q_ff[q_tail_ff] <= push_word;
      end
   end

   // Byte store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         store_ff[mem_addr] <= req_word.data_in;
      end
      if (accept) begin
         rd_data_ff <= store_ff[mem_addr];
      end
   end

   // The write pointer always sits the occupancy ahead of the read pointer.
   logic [EXT_W-1:0] chk_sum;
   logic [PTR_W-1:0] chk_wr;
   always_comb begin
      chk_sum = EXT_W'(rd_ptr_ff) + occ_x;
      if (chk_sum >= DEPTH_X) begin
         chk_sum = chk_sum - DEPTH_X;
      end
      chk_wr = chk_sum[PTR_W-1:0];
   end

   `BRBO_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_x <= DEPTH_X,
      "occupancy exceeds the buffer depth")
   `BRBO_ASSERT_NOW(a_ptr_link, clock, reset, 1'b1, chk_wr == wr_ptr_ff,
      "write pointer does not match read pointer plus occupancy")
   `BRBO_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, q_cnt_ff <= 2'd2,
      "output queue holds more than two words")
   `BRBO_ASSERT_NEXT(a_refused_commit, clock, reset,
      accept && (req_word.action == brbo_pkg::ACT_COMMIT) && !s1_in.rsp.ok,
      $stable(wr_ptr_ff) && $stable(occ_ff),
      "refused commit changed the write pointer or occupancy")
   `BRBO_ASSERT_NOW(a_level_sum, clock, reset, (DEPTH < 8192) && push,
      (EXT_W'(push_word.fill_level) + EXT_W'(push_word.free_space)) == DEPTH_X,
      "fill level and free space do not add up to the depth")

endmodule

`default_nettype wire
